>>> rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the sensor frame deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // frame positions fit in 5 bits for every supported frame length (24..32)
  localparam int unsigned POS_W = 5;

  localparam logic [7:0] HEADER_RESET = 8'hAA;

  // what the back end has to do with one byte
  typedef enum logic [1:0] {
    OP_DROP = 2'd0,  // not a header while hunting
    OP_DATA = 2'd1,  // frame byte before the checksum
    OP_GOOD = 2'd2,  // checksum byte, sum matches
    OP_BAD  = 2'd3   // checksum byte, sum mismatch
  } sfd_op_e;

  typedef struct packed {
    sfd_op_e          op;
    logic [7:0]       data;
    logic [POS_W-1:0] idx;
  } sfd_item_t;

endpackage

>>> rtl/sensor_frame_deframer.sv
// ----------------------------------------------------------------------------
// sensor_frame_deframer
// Header-synchronized fixed-length frame parser with 8-bit sum checksum.
// ----------------------------------------------------------------------------
//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------
//  config    | cfg_we_i               | cfg_wdata_i (header byte)
//  input     | in_valid_i/in_ready_o  | in_byte_i
//  output    | out_valid_o/out_ready_i| frame_done_o .. resyncs_o
//
//  one byte per cycle sustained while the output keeps taking results; the
//  front classifies an accepted byte into the queue at the accepting edge,
//  and the back end moves it from the queue into the result reg once that
//  reg is free or being taken; the two-entry queue absorbs output stalls;
//  input ready drops only when the queue is full
//  reset: header byte 0xAA, hunting for a header, counters and frame cleared
// ----------------------------------------------------------------------------
module sensor_frame_deframer #(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        frame_done_o,
  output logic        checksum_fail_o,
  output logic        have_frame_o,
  output logic [15:0] frame_seq_o,
  output logic [31:0] frame_tick_o,
  output logic [63:0] quat_words_o,
  output logic [47:0] gyro_words_o,
  output logic [15:0] pulse_rate_o,
  output logic [31:0] byte_count_o,
  output logic [31:0] good_frames_o,
  output logic [31:0] bad_frames_o,
  output logic [31:0] resyncs_o
);
  import sfd_pkg::*;

  logic      push, push_ready, pop_valid, pop_ready;
  sfd_item_t push_item, pop_item;

  sfd_front #(.FRAME_BYTES(FRAME_BYTES)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_byte_i    (in_byte_i),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_ready_i (push_ready)
  );

  sfd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_item_i  (push_item),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_item_o   (pop_item),
    .pop_ready_i  (pop_ready)
  );

  sfd_back #(.FRAME_BYTES(FRAME_BYTES)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pop_valid_i     (pop_valid),
    .pop_item_i      (pop_item),
    .pop_ready_o     (pop_ready),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .frame_done_o    (frame_done_o),
    .checksum_fail_o (checksum_fail_o),
    .have_frame_o    (have_frame_o),
    .frame_seq_o     (frame_seq_o),
    .frame_tick_o    (frame_tick_o),
    .quat_words_o    (quat_words_o),
    .gyro_words_o    (gyro_words_o),
    .pulse_rate_o    (pulse_rate_o),
    .byte_count_o    (byte_count_o),
    .good_frames_o   (good_frames_o),
    .bad_frames_o    (bad_frames_o),
    .resyncs_o       (resyncs_o)
  );

`ifndef SYNTHESIS
  a_done_fail_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_done_o && checksum_fail_o))
    else $error("frame reported both good and bad");

  a_done_has_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> have_frame_o)
    else $error("good frame without have_frame");

  a_one_byte_per_transaction: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=>
      (byte_count_o == $past(byte_count_o) || byte_count_o == $past(byte_count_o) + 32'd1))
    else $error("byte count stepped by more than one");

  a_queue_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_valid && (!out_valid_o || out_ready_i)) |=> out_valid_o)
    else $error("queued byte not moved to the result register");
`endif

endmodule

>>> rtl/sfd_front.sv
// ----------------------------------------------------------------------------
// sfd_front
// Accepts bytes, tracks the frame position and running sum, classifies each.
// ----------------------------------------------------------------------------
module sfd_front #(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  output logic              push_o,
  output sfd_pkg::sfd_item_t push_item_o,
  input  logic              push_ready_i
);
  import sfd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  logic [7:0]       header_q;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       sum_q, sum_d;
  logic             accept;

  assign in_ready_o = push_ready_i;
  assign accept     = in_valid_i & push_ready_i;
  assign push_o     = accept;

  always_comb begin
    pos_d            = pos_q;
    sum_d            = sum_q;
    push_item_o.data = in_byte_i;
    push_item_o.idx  = pos_q;
    if (pos_q == '0 && in_byte_i != header_q) begin
      push_item_o.op = OP_DROP;
    end else if (pos_q < LAST_POS) begin
      push_item_o.op = OP_DATA;
      sum_d          = sum_q + in_byte_i;
      pos_d          = pos_q + 1'b1;
    end else begin
      push_item_o.op = (sum_q == in_byte_i) ? OP_GOOD : OP_BAD;
      sum_d          = '0;
      pos_d          = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_q <= HEADER_RESET;
      pos_q    <= '0;
      sum_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        header_q <= cfg_wdata_i;
      end
      if (accept) begin
        pos_q <= pos_d;
        sum_q <= sum_d;
      end
    end
  end

endmodule

>>> rtl/sfd_queue.sv
// ----------------------------------------------------------------------------
// sfd_queue
// Two-entry queue of classified bytes between front and back end.
// ----------------------------------------------------------------------------
module sfd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  sfd_pkg::sfd_item_t push_item_i,
  output logic               push_ready_o,
  output logic               pop_valid_o,
  output sfd_pkg::sfd_item_t pop_item_o,
  input  logic               pop_ready_i
);
  import sfd_pkg::*;

  sfd_item_t  entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign do_push      = push_i & push_ready_o;
  assign do_pop       = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> rtl/sfd_back.sv
// ----------------------------------------------------------------------------
// sfd_back
// Stores frame bytes, decodes good frames, keeps counters, holds the result.
// ----------------------------------------------------------------------------
module sfd_back #(
  parameter int unsigned FRAME_BYTES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  input  sfd_pkg::sfd_item_t pop_item_i,
  output logic               pop_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               frame_done_o,
  output logic               checksum_fail_o,
  output logic               have_frame_o,
  output logic [15:0]        frame_seq_o,
  output logic [31:0]        frame_tick_o,
  output logic [63:0]        quat_words_o,
  output logic [47:0]        gyro_words_o,
  output logic [15:0]        pulse_rate_o,
  output logic [31:0]        byte_count_o,
  output logic [31:0]        good_frames_o,
  output logic [31:0]        bad_frames_o,
  output logic [31:0]        resyncs_o
);
  import sfd_pkg::*;

  localparam int unsigned STORE_DEPTH = FRAME_BYTES - 1;

  logic [7:0]  store_q [STORE_DEPTH];
  logic        out_valid_q, done_q, fail_q, seen_q;
  logic [15:0] seq_q, hr_q;
  logic [31:0] tick_q;
  logic [63:0] quat_q;
  logic [47:0] gyro_q;
  logic [31:0] byte_cnt_q, good_q, bad_q, resync_q;
  logic        pop;

  // the result register is free or is being taken this cycle
  assign pop_ready_o = ~out_valid_q | out_ready_i;
  assign pop         = pop_valid_i & pop_ready_o;

  for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_store
    always_ff @(posedge clk_i) begin
      if (pop && pop_item_i.op == OP_DATA && pop_item_i.idx == POS_W'(i)) begin
        store_q[i] <= pop_item_i.data;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      fail_q      <= 1'b0;
      seen_q      <= 1'b0;
      seq_q       <= '0;
      tick_q      <= '0;
      quat_q      <= '0;
      gyro_q      <= '0;
      hr_q        <= '0;
      byte_cnt_q  <= '0;
      good_q      <= '0;
      bad_q       <= '0;
      resync_q    <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
        done_q      <= (pop_item_i.op == OP_GOOD);
        fail_q      <= (pop_item_i.op == OP_BAD);
        byte_cnt_q  <= byte_cnt_q + 32'd1;
        case (pop_item_i.op)
          OP_DROP: begin
            resync_q <= resync_q + 32'd1;
          end
          OP_GOOD: begin
            seen_q <= 1'b1;
            good_q <= good_q + 32'd1;
            seq_q  <= {store_q[2], store_q[1]};
            tick_q <= {store_q[6], store_q[5], store_q[4], store_q[3]};
            quat_q <= {store_q[14], store_q[13], store_q[12], store_q[11],
                       store_q[10], store_q[9], store_q[8], store_q[7]};
            gyro_q <= {store_q[20], store_q[19], store_q[18],
                       store_q[17], store_q[16], store_q[15]};
            hr_q   <= {store_q[22], store_q[21]};
          end
          OP_BAD: begin
            bad_q <= bad_q + 32'd1;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign frame_done_o    = done_q;
  assign checksum_fail_o = fail_q;
  assign have_frame_o    = seen_q;
  assign frame_seq_o     = seq_q;
  assign frame_tick_o    = tick_q;
  assign quat_words_o    = quat_q;
  assign gyro_words_o    = gyro_q;
  assign pulse_rate_o    = hr_q;
  assign byte_count_o    = byte_cnt_q;
  assign good_frames_o   = good_q;
  assign bad_frames_o    = bad_q;
  assign resyncs_o       = resync_q;

endmodule

>>> test/tb_sensor_frame_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_deframer
// Self-checking bench: a byte stream of well-formed, corrupted and cut-short
// frames mixed with line noise goes through the deframer under several header
// settings and idling mixes; every result is checked against a local model.
// ----------------------------------------------------------------------------
module tb_sensor_frame_deframer;
  import sfd_pkg::*;

  localparam int unsigned FRAME_BYTES = 24;
  localparam int SEG_ITEMS = 188;
  localparam int HOLD_AT = 900;     // input transaction that starts the long hold-off
  localparam int HOLD_CYCLES = 60;
  localparam int WD_LIMIT = 4000;
  localparam int MAX_PRINTS = 40;

  typedef logic [7:0] octet_t;

  typedef struct packed {
    logic        done;
    logic        fail;
    logic        have;
    logic [15:0] seq;
    logic [31:0] tick;
    logic [63:0] quat;
    logic [47:0] gyro;
    logic [15:0] rate;
    logic [31:0] n_bytes;
    logic [31:0] n_good;
    logic [31:0] n_bad;
    logic [31:0] n_resync;
  } deframe_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [7:0]  cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  in_byte_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        frame_done_o;
  logic        checksum_fail_o;
  logic        have_frame_o;
  logic [15:0] frame_seq_o;
  logic [31:0] frame_tick_o;
  logic [63:0] quat_words_o;
  logic [47:0] gyro_words_o;
  logic [15:0] pulse_rate_o;
  logic [31:0] byte_count_o;
  logic [31:0] good_frames_o;
  logic [31:0] bad_frames_o;
  logic [31:0] resyncs_o;

  sensor_frame_deframer #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_done_o   (frame_done_o),
    .checksum_fail_o(checksum_fail_o),
    .have_frame_o   (have_frame_o),
    .frame_seq_o    (frame_seq_o),
    .frame_tick_o   (frame_tick_o),
    .quat_words_o   (quat_words_o),
    .gyro_words_o   (gyro_words_o),
    .pulse_rate_o   (pulse_rate_o),
    .byte_count_o   (byte_count_o),
    .good_frames_o  (good_frames_o),
    .bad_frames_o   (bad_frames_o),
    .resyncs_o      (resyncs_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // stimulus and expectations
  octet_t       line_q[$];
  deframe_res_t frame_exp_q[$];
  int           tx_idle_pct = 0;
  int           rx_idle_pct = 0;
  int           errors = 0;
  int           hdr_settings = 0;

  // deframer model state
  octet_t      hdr_model = HEADER_RESET;
  octet_t      frame_buf[FRAME_BYTES-1];
  int          buf_pos = 0;
  octet_t      buf_sum = '0;
  logic        have_model = 1'b0;
  logic [15:0] last_seq = '0;
  logic [31:0] last_tick = '0;
  logic [63:0] last_quat = '0;
  logic [47:0] last_gyro = '0;
  logic [15:0] last_rate = '0;
  logic [31:0] cnt_bytes = '0;
  logic [31:0] cnt_good = '0;
  logic [31:0] cnt_bad = '0;
  logic [31:0] cnt_resync = '0;

  task automatic deframe_byte(input octet_t b);
    sfd_op_e      op;
    deframe_res_t r;
    cnt_bytes++;
    if (buf_pos == 0 && b != hdr_model) op = OP_DROP;
    else if (buf_pos < FRAME_BYTES - 1) op = OP_DATA;
    else if (buf_sum == b) op = OP_GOOD;
    else op = OP_BAD;
    case (op)
      OP_DROP: cnt_resync++;
      OP_DATA: begin
        frame_buf[buf_pos] = b;
        buf_sum = buf_sum + b;
        buf_pos++;
      end
      OP_GOOD: begin
        // little-endian fields after the header byte
        last_seq = {frame_buf[2], frame_buf[1]};
        for (int i = 0; i < 4; i++) last_tick[8*i +: 8] = frame_buf[3+i];
        for (int i = 0; i < 8; i++) last_quat[8*i +: 8] = frame_buf[7+i];
        for (int i = 0; i < 6; i++) last_gyro[8*i +: 8] = frame_buf[15+i];
        last_rate = {frame_buf[22], frame_buf[21]};
        have_model = 1'b1;
        cnt_good++;
      end
      default: cnt_bad++;
    endcase
    if (op == OP_GOOD || op == OP_BAD) begin
      buf_pos = 0;
      buf_sum = '0;
    end
    r.done = (op == OP_GOOD);
    r.fail = (op == OP_BAD);
    r.have = have_model;
    r.seq = last_seq;
    r.tick = last_tick;
    r.quat = last_quat;
    r.gyro = last_gyro;
    r.rate = last_rate;
    r.n_bytes = cnt_bytes;
    r.n_good = cnt_good;
    r.n_bad = cnt_bad;
    r.n_resync = cnt_resync;
    frame_exp_q.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= MAX_PRINTS)
      $display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic cmp_field(input string what, input logic [63:0] got,
                           input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_result();
    deframe_res_t want;
    if (frame_exp_q.size() == 0) begin
      report_mismatch("unexpected result", {32'b0, byte_count_o}, '0);
    end else begin
      want = frame_exp_q.pop_front();
      cmp_field("frame_done", frame_done_o, want.done);
      cmp_field("checksum_fail", checksum_fail_o, want.fail);
      cmp_field("have_frame", have_frame_o, want.have);
      cmp_field("frame_seq", frame_seq_o, want.seq);
      cmp_field("frame_tick", frame_tick_o, want.tick);
      cmp_field("quat_words", quat_words_o, want.quat);
      cmp_field("gyro_words", gyro_words_o, want.gyro);
      cmp_field("pulse_rate", pulse_rate_o, want.rate);
      cmp_field("byte_count", byte_count_o, want.n_bytes);
      cmp_field("good_frames", good_frames_o, want.n_good);
      cmp_field("bad_frames", bad_frames_o, want.n_bad);
      cmp_field("resyncs", resyncs_o, want.n_resync);
    end
  endtask

  // driver: one byte per input transaction, payload held until accepted
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) deframe_byte(in_byte_i);
      if (!in_valid_i || in_ready_o) begin
        if (line_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
          in_valid_i <= 1'b1;
          in_byte_i <= line_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, started by a given input transaction
  int in_seen = 0;
  int hold_left = 0;
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        in_seen <= in_seen + 1;
        if (in_seen == HOLD_AT) hold_left <= HOLD_CYCLES;
      end
      if (hold_left != 0 && !(in_valid_i && in_ready_o && in_seen == HOLD_AT))
        hold_left <= hold_left - 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) check_result();
      out_ready_i <= (hold_left == 0) && ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // watchdog on stretches without any transaction
  int stuck_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == WD_LIMIT) begin
      $display("timeout: no transaction for %0d cycles", WD_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic wait_drained();
    @(negedge clk_i);
    while (line_q.size() != 0 || in_valid_i || frame_exp_q.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic write_header(input octet_t value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    hdr_model = value;
    hdr_settings++;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // header, body, then the wrapping sum (optionally spoiled)
  task automatic queue_frame(input octet_t body[$], input bit corrupt);
    octet_t sum;
    sum = hdr_model;
    line_q.push_back(hdr_model);
    foreach (body[i]) begin
      line_q.push_back(body[i]);
      sum = sum + body[i];
    end
    if (corrupt) sum = sum ^ octet_t'($urandom_range(1, 255));
    line_q.push_back(sum);
  endtask

  task automatic queue_segment(input int n_items);
    int     start;
    int     kind;
    int     fill;
    octet_t body[$];
    start = line_q.size();
    while (line_q.size() - start < n_items) begin
      kind = $urandom_range(15);
      if (kind < 2) begin
        repeat ($urandom_range(1, 4)) line_q.push_back(octet_t'($urandom_range(255)));
      end else if (kind == 2) begin
        // cut short: the next header lands inside this frame as data
        line_q.push_back(hdr_model);
        repeat ($urandom_range(1, FRAME_BYTES - 2))
          line_q.push_back(octet_t'($urandom_range(255)));
      end else begin
        fill = $urandom_range(7);
        body.delete();
        for (int i = 0; i < FRAME_BYTES - 2; i++) begin
          case (fill)
            0: body.push_back(8'h00);
            1: body.push_back(8'hFF);
            2: body.push_back(($urandom_range(3) == 0) ? hdr_model
                                                       : octet_t'($urandom_range(255)));
            default: body.push_back(octet_t'($urandom_range(255)));
          endcase
        end
        queue_frame(body, $urandom_range(3) == 0);
      end
    end
  endtask

  initial begin
    octet_t body[$];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: noise before any frame, then one frame with extreme fields
    // and the header value inside its payload
    tx_idle_pct = 20;
    rx_idle_pct = 79;
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    body = '{8'hFF, 8'hFF,                       // seq
             8'h00, 8'h00, 8'h00, 8'h80,         // tick
             8'hFF, 8'h7F, 8'h00, 8'h80,         // quat 0..1
             8'hFF, 8'hFF, 8'h00, 8'h00,         // quat 2..3
             8'h00, 8'h80, 8'hFF, 8'h7F,         // gyro 0..1
             8'h01, 8'h00,                       // gyro 2
             HEADER_RESET, HEADER_RESET};        // pulse rate
    queue_frame(body, 1'b0);

    for (int seg = 0; seg < 6; seg++) begin
      wait_drained();
      tx_idle_pct = (seg < 2) ? 20 : (seg < 4) ? 79 : 0;
      rx_idle_pct = (seg < 2) ? 79 : (seg < 4) ? 20 : 0;
      case (seg)
        0: write_header(8'h00);
        1: write_header(8'hFF);
        3: write_header(HEADER_RESET);
        default: write_header(octet_t'($urandom_range(255)));
      endcase
      queue_segment(SEG_ITEMS);
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    $display("covered %0d bytes: %0d good frames, %0d bad checksums, %0d resyncs",
             cnt_bytes, cnt_good, cnt_bad, cnt_resync);
    $display("%0d header settings, three idling mixes, one long receiver hold-off",
             hdr_settings);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
